@@ rtl/spgemm_row_structure_counter_assert.svh @@
// assertion macros for the row structure counter checker
// no dependencies; included by files that assert
`ifndef SPGEMM_ROW_STRUCTURE_COUNTER_ASSERT_SVH
`define SPGEMM_ROW_STRUCTURE_COUNTER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define RSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rsc_pkg.sv @@
// shared constants and types of the row structure counter
// no dependencies
package rsc_pkg;

  localparam int MAX_COLS = 4096;
  localparam int IDX_W    = $clog2(MAX_COLS);
  localparam int CNT_W    = $clog2(MAX_COLS + 1);
  localparam int COL_W    = 12;
  localparam int ROWC_W   = 13;
  localparam int VAL_W    = 31;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic [VAL_W-1:0] VAL31_MAX = {VAL_W{1'b1}};

  localparam logic [0:0] REG_NNZ_LIMIT = 1'b0;

  localparam logic KIND_COLUMN  = 1'b0;
  localparam logic KIND_ROW_END = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_ENDR = 3'b100
  } state_t;

  typedef struct packed {
    logic             lk_en;
    logic [IDX_W-1:0] lk_addr;
    logic             mk_en;
    logic [IDX_W-1:0] mk_addr;
    logic [IDX_W-1:0] mk_slot;
    logic [COL_W-1:0] mk_col;
    logic             clr_start;
    logic [CNT_W-1:0] clr_cnt;
  } mark_req_t;

  typedef struct packed {
    logic busy;
    logic seen;
  } mark_sts_t;

endpackage

@@ rtl/rsc_cfg.sv @@
// configuration register port holding nnz_limit
// depends on rsc_pkg
module rsc_cfg import rsc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output logic [VAL_W-1:0]  nnz_limit
);

  logic [VAL_W-1:0] limit_r;
  logic [0:0]       reg_idx;
  logic             wr_en;

  assign reg_idx    = cfg_paddr[2:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && (reg_idx == REG_NNZ_LIMIT);
  assign cfg_pready = 1'b1;
  assign nnz_limit  = limit_r;

  always_comb begin
    case (reg_idx)
      REG_NNZ_LIMIT: cfg_prdata = {1'b0, limit_r};
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= VAL31_MAX;
    end else if (wr_en) begin
      limit_r <= cfg_pwdata[VAL_W-1:0];
    end
  end

endmodule

@@ rtl/rsc_mark.sv @@
// seen bitmap and touched list memories, reset sweep and end-of-row clear walk
// depends on rsc_pkg
module rsc_mark import rsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  mark_req_t req,
  output mark_sts_t sts
);

  logic             seen_mem [MAX_COLS];
  logic [COL_W-1:0] tl_mem   [MAX_COLS];

  logic             seen_q_r;
  logic [COL_W-1:0] tl_q_r;
  logic             init_r;
  logic [IDX_W-1:0] init_addr_r;
  logic             clr_act_r;
  logic             clr_pend_r;
  logic [CNT_W-1:0] clr_idx_r;
  logic [CNT_W-1:0] clr_cnt_r;

  logic             seen_we;
  logic [IDX_W-1:0] seen_waddr;
  logic             seen_wdata;
  logic             tl_rd;

  assign tl_rd    = clr_act_r && (clr_idx_r < clr_cnt_r);
  assign sts.busy = init_r || clr_act_r || clr_pend_r;
  assign sts.seen = seen_q_r;

  always_comb begin
    seen_we    = 1'b0;
    seen_waddr = req.mk_addr;
    seen_wdata = 1'b1;
    if (init_r) begin
      seen_we    = 1'b1;
      seen_waddr = init_addr_r;
      seen_wdata = 1'b0;
    end else if (clr_pend_r) begin
      seen_we    = 1'b1;
      seen_waddr = IDX_W'(tl_q_r);
      seen_wdata = 1'b0;
    end else if (req.mk_en) begin
      seen_we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (seen_we) begin
      seen_mem[seen_waddr] <= seen_wdata;
    end
    if (req.lk_en) begin
      seen_q_r <= seen_mem[req.lk_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.mk_en) begin
      tl_mem[req.mk_slot] <= req.mk_col;
    end
    if (tl_rd) begin
      tl_q_r <= tl_mem[clr_idx_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r      <= 1'b1;
      init_addr_r <= '0;
      clr_act_r   <= 1'b0;
      clr_pend_r  <= 1'b0;
      clr_idx_r   <= '0;
      clr_cnt_r   <= '0;
    end else begin
      if (init_r) begin
        init_addr_r <= init_addr_r + 1'b1;
        if (init_addr_r == IDX_W'(MAX_COLS - 1)) begin
          init_r <= 1'b0;
        end
      end
      clr_pend_r <= tl_rd;
      if (req.clr_start && (req.clr_cnt != '0)) begin
        clr_act_r <= 1'b1;
        clr_idx_r <= '0;
        clr_cnt_r <= req.clr_cnt;
      end else if (clr_act_r) begin
        if (tl_rd) begin
          clr_idx_r <= clr_idx_r + 1'b1;
        end else begin
          clr_act_r <= 1'b0;
        end
      end
    end
  end

endmodule

@@ rtl/spgemm_row_structure_counter.sv @@
// Symbolic-phase row structure counter for row-by-row sparse products.
// Input channel (in_valid/in_stall): words of kind column carry one gathered
// column index; a word of kind row end closes the current output row.
// Result channel (out_valid/out_stall): one word per input word. Column words
// echo the column and flag its first occurrence in the row; row end words
// give distinct count, start offset, product count and running total.
// Configuration: APB-style port, register 0 is nnz_limit; a total above it
// sets the sticky overflow flag and saturates the total.
// Timing: a column word's seen bit is read into a register on accept; its result
// is registered from it in LOOK once the output is free, and the bitmap write
// back happens in that same cycle, so no column word is taken while one is in
// LOOK. A row end word's result is registered from ENDR once the output is free,
// then, if the row touched any column, the touched list is walked to clear the
// marks, one bitmap write per cycle; in_stall stays high meanwhile.
// Reset: synchronous, active low. Afterwards the bitmap is swept to zero over all
// MAX_COLS addresses (4096) with in_stall high; configuration writes still go.
// A stalled result holds in the output register; the next input word is
// accepted, and its result waits in the bitmap pipe until the output frees.
// depends on rsc_pkg, rsc_cfg, rsc_mark
module spgemm_row_structure_counter import rsc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_kind,
  input  logic [COL_W-1:0]  in_column,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_row_end,
  output logic [COL_W-1:0]  out_column_out,
  output logic              out_first_seen,
  output logic [ROWC_W-1:0] out_row_count,
  output logic [VAL_W-1:0]  out_row_start,
  output logic [VAL_W-1:0]  out_row_ops,
  output logic [VAL_W-1:0]  out_run_total,
  output logic              out_overflow,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [VAL_W-1:0] nnz_limit;
  mark_req_t        mreq;
  mark_sts_t        msts;

  state_t            state_r, state_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [CNT_W-1:0]  distinct_r, distinct_nxt;
  logic [VAL_W-1:0]  ops_r, ops_nxt;
  logic [VAL_W-1:0]  total_r, total_nxt;
  logic              ovf_r, ovf_nxt;

  logic              ov_r, ov_nxt;
  logic              o_end_r, o_end_nxt;
  logic [COL_W-1:0]  o_col_r, o_col_nxt;
  logic              o_first_r, o_first_nxt;
  logic [ROWC_W-1:0] o_cnt_r, o_cnt_nxt;
  logic [VAL_W-1:0]  o_start_r, o_start_nxt;
  logic [VAL_W-1:0]  o_ops_r, o_ops_nxt;
  logic [VAL_W-1:0]  o_total_r, o_total_nxt;
  logic              o_ovf_r, o_ovf_nxt;

  logic              accept;
  logic              out_free;
  logic              in_range;
  logic              first;
  logic [VAL_W:0]    sum;

  rsc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .nnz_limit   (nnz_limit)
  );

  rsc_mark u_mark (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .sts   (msts)
  );

  assign in_stall = (state_r != ST_IDLE) || msts.busy;
  assign accept   = in_valid && !in_stall;
  assign out_free = !ov_r || !out_stall;
  assign in_range = 32'(col_r) < 32'(MAX_COLS);
  assign first    = in_range && !msts.seen;
  assign sum      = {1'b0, total_r} + (VAL_W + 1)'(distinct_r);

  always_comb begin
    state_nxt    = state_r;
    col_nxt      = col_r;
    distinct_nxt = distinct_r;
    ops_nxt      = ops_r;
    total_nxt    = total_r;
    ovf_nxt      = ovf_r;

    ov_nxt       = ov_r && out_stall;
    o_end_nxt    = o_end_r;
    o_col_nxt    = o_col_r;
    o_first_nxt  = o_first_r;
    o_cnt_nxt    = o_cnt_r;
    o_start_nxt  = o_start_r;
    o_ops_nxt    = o_ops_r;
    o_total_nxt  = o_total_r;
    o_ovf_nxt    = o_ovf_r;

    mreq           = '0;
    mreq.lk_addr   = IDX_W'(in_column);
    mreq.mk_addr   = IDX_W'(col_r);
    mreq.mk_slot   = distinct_r[IDX_W-1:0];
    mreq.mk_col    = col_r;
    mreq.clr_cnt   = distinct_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          col_nxt = in_column;
          if (in_kind == KIND_ROW_END) begin
            state_nxt = ST_ENDR;
          end else begin
            mreq.lk_en = 1'b1;
            state_nxt  = ST_LOOK;
          end
        end
      end
      ST_LOOK: begin
        if (out_free) begin
          if (ops_r != VAL31_MAX) begin
            ops_nxt = ops_r + 1'b1;
          end
          if (first) begin
            mreq.mk_en   = 1'b1;
            distinct_nxt = distinct_r + 1'b1;
          end
          ov_nxt      = 1'b1;
          o_end_nxt   = 1'b0;
          o_col_nxt   = col_r;
          o_first_nxt = first;
          o_cnt_nxt   = '0;
          o_start_nxt = '0;
          o_ops_nxt   = '0;
          o_total_nxt = total_r;
          o_ovf_nxt   = ovf_r;
          state_nxt   = ST_IDLE;
        end
      end
      ST_ENDR: begin
        if (out_free) begin
          if (sum > {1'b0, nnz_limit}) begin
            ovf_nxt   = 1'b1;
            total_nxt = nnz_limit;
          end else begin
            total_nxt = sum[VAL_W-1:0];
          end
          mreq.clr_start = 1'b1;
          ov_nxt         = 1'b1;
          o_end_nxt      = 1'b1;
          o_col_nxt      = '0;
          o_first_nxt    = 1'b0;
          o_cnt_nxt      = ROWC_W'(distinct_r);
          o_start_nxt    = total_r;
          o_ops_nxt      = ops_r;
          o_total_nxt    = total_nxt;
          o_ovf_nxt      = ovf_nxt;
          distinct_nxt   = '0;
          ops_nxt        = '0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      distinct_r <= '0;
      ops_r      <= '0;
      total_r    <= '0;
      ovf_r      <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      distinct_r <= distinct_nxt;
      ops_r      <= ops_nxt;
      total_r    <= total_nxt;
      ovf_r      <= ovf_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r     <= col_nxt;
    o_end_r   <= o_end_nxt;
    o_col_r   <= o_col_nxt;
    o_first_r <= o_first_nxt;
    o_cnt_r   <= o_cnt_nxt;
    o_start_r <= o_start_nxt;
    o_ops_r   <= o_ops_nxt;
    o_total_r <= o_total_nxt;
    o_ovf_r   <= o_ovf_nxt;
  end

  assign out_valid      = ov_r;
  assign out_row_end    = o_end_r;
  assign out_column_out = o_col_r;
  assign out_first_seen = o_first_r;
  assign out_row_count  = o_cnt_r;
  assign out_row_start  = o_start_r;
  assign out_row_ops    = o_ops_r;
  assign out_run_total  = o_total_r;
  assign out_overflow   = o_ovf_r;

endmodule

@@ rtl/rsc_checker.sv @@
// port-level checker for the row structure counter, bound to the top level
// depends on rsc_pkg and spgemm_row_structure_counter_assert.svh
`include "spgemm_row_structure_counter_assert.svh"

module rsc_checker import rsc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_row_end,
  input logic [COL_W-1:0]  out_column_out,
  input logic              out_first_seen,
  input logic [ROWC_W-1:0] out_row_count,
  input logic [VAL_W-1:0]  out_row_start,
  input logic [VAL_W-1:0]  out_row_ops,
  input logic [VAL_W-1:0]  out_run_total,
  input logic              out_overflow
);

  logic           ovf_seen_r;
  logic           held;
  logic [VAL_W:0] word_bits;
  logic           row_zero;
  logic           row_ok;

  assign held      = out_valid && out_stall;
  assign word_bits = {out_row_end, out_run_total};
  assign row_zero  = (out_row_count == '0) && (out_row_start == '0) && (out_row_ops == '0);
  assign row_ok    = !out_first_seen && (out_column_out == '0) &&
                     (VAL_W'(out_row_count) <= out_row_ops);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_seen_r <= 1'b0;
    end else if (out_valid && out_overflow) begin
      ovf_seen_r <= 1'b1;
    end
  end

  `RSC_ASSERT_NEXT(a_out_hold, held, out_valid && $stable(word_bits), "held word changed")
  `RSC_ASSERT_NOW(a_ovf_sticky, out_valid && ovf_seen_r, out_overflow, "overflow flag dropped")
  `RSC_ASSERT_NOW(a_col_word_zero, out_valid && !out_row_end, row_zero, "row fields on column word")
  `RSC_ASSERT_NOW(a_row_word, out_valid && out_row_end, row_ok, "row end word inconsistent")

endmodule

bind spgemm_row_structure_counter rsc_checker u_rsc_checker (.*);

@@ sim/spgemm_row_structure_counter_check.sv @@
// checker for the row structure counter: tracks seen columns, row totals and
// overflow from the accepted input words and compares every result word
// depends on rsc_pkg
module spgemm_row_structure_counter_check import rsc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              in_kind,
  input  logic [COL_W-1:0]  in_column,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              out_row_end,
  input  logic [COL_W-1:0]  out_column_out,
  input  logic              out_first_seen,
  input  logic [ROWC_W-1:0] out_row_count,
  input  logic [VAL_W-1:0]  out_row_start,
  input  logic [VAL_W-1:0]  out_row_ops,
  input  logic [VAL_W-1:0]  out_run_total,
  input  logic              out_overflow,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  input  logic              cfg_pready,
  output int                mismatches,
  output int                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_AW-1:0] LIMIT_ADDR = CFG_AW'(4 * REG_NNZ_LIMIT);

  typedef struct packed {
    logic              row_end;
    logic [COL_W-1:0]  column_out;
    logic              first_seen;
    logic [ROWC_W-1:0] row_count;
    logic [VAL_W-1:0]  row_start;
    logic [VAL_W-1:0]  row_ops;
    logic [VAL_W-1:0]  run_total;
    logic              overflow;
  } row_word_t;

  bit               col_marked [MAX_COLS];
  logic [COL_W-1:0] touched_cols [$];
  logic [VAL_W-1:0] row_products;
  logic [VAL_W-1:0] nnz_total;
  logic [VAL_W-1:0] nnz_limit_q;
  logic             nnz_overflowed;
  row_word_t        expected_words [$];
  row_word_t        got_word;
  row_word_t        want_word;

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      flag_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  task automatic tally_word(input logic kind, input logic [COL_W-1:0] col);
    row_word_t    w;
    logic [VAL_W:0] sum;
    w = '0;
    if (kind == KIND_COLUMN) begin
      if (row_products != VAL31_MAX)
        row_products++;
      w.column_out = col;
      if (!col_marked[col]) begin
        col_marked[col] = 1'b1;
        touched_cols.push_back(col);
        w.first_seen = 1'b1;
      end
    end else begin
      w.row_end = 1'b1;
      w.row_count = ROWC_W'(touched_cols.size());
      w.row_start = nnz_total;
      w.row_ops = row_products;
      sum = {1'b0, nnz_total} + (VAL_W + 1)'(touched_cols.size());
      if (sum > {1'b0, nnz_limit_q}) begin
        nnz_overflowed = 1'b1;
        nnz_total = nnz_limit_q;
      end else begin
        nnz_total = sum[VAL_W-1:0];
      end
      foreach (touched_cols[i])
        col_marked[touched_cols[i]] = 1'b0;
      touched_cols.delete();
      row_products = '0;
    end
    w.run_total = nnz_total;
    w.overflow = nnz_overflowed;
    expected_words.push_back(w);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (col_marked[i])
        col_marked[i] = 1'b0;
      touched_cols.delete();
      expected_words.delete();
      row_products = '0;
      nnz_total = '0;
      nnz_limit_q = VAL31_MAX;
      nnz_overflowed = 1'b0;
      mismatches = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == LIMIT_ADDR)
        nnz_limit_q = cfg_pwdata[VAL_W-1:0];
      if (out_valid && !out_stall) begin
        got_word = {out_row_end, out_column_out, out_first_seen, out_row_count,
                    out_row_start, out_row_ops, out_run_total, out_overflow};
        if (expected_words.size() == 0) begin
          flag_mismatch("result word with nothing expected");
        end else begin
          want_word = expected_words.pop_front();
          check_field("row_end", 32'(got_word.row_end), 32'(want_word.row_end));
          check_field("column_out", 32'(got_word.column_out), 32'(want_word.column_out));
          check_field("first_seen", 32'(got_word.first_seen), 32'(want_word.first_seen));
          check_field("row_count", 32'(got_word.row_count), 32'(want_word.row_count));
          check_field("row_start", 32'(got_word.row_start), 32'(want_word.row_start));
          check_field("row_ops", 32'(got_word.row_ops), 32'(want_word.row_ops));
          check_field("run_total", 32'(got_word.run_total), 32'(want_word.run_total));
          check_field("overflow", 32'(got_word.overflow), 32'(want_word.overflow));
        end
      end
      if (in_valid && !in_stall)
        tally_word(in_kind, in_column);
    end
    outstanding <= expected_words.size();
  end

endmodule

@@ sim/spgemm_row_structure_counter_test.sv @@
// top of the row structure counter simulation: clock, reset, column and row
// end words, nnz_limit writes and result stalls; the checker does the scoring
// depends on rsc_pkg, spgemm_row_structure_counter, spgemm_row_structure_counter_check
module spgemm_row_structure_counter_test import rsc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 800000;
  localparam int RANDOM_ITEMS = 1350;
  localparam logic [CFG_AW-1:0] LIMIT_ADDR = CFG_AW'(4 * REG_NNZ_LIMIT);

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_kind = KIND_COLUMN;
  logic [COL_W-1:0]  in_column = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_row_end;
  logic [COL_W-1:0]  out_column_out;
  logic              out_first_seen;
  logic [ROWC_W-1:0] out_row_count;
  logic [VAL_W-1:0]  out_row_start;
  logic [VAL_W-1:0]  out_row_ops;
  logic [VAL_W-1:0]  out_run_total;
  logic              out_overflow;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;
  int                mismatches;
  int                outstanding;

  int send_idle_pct = 26;
  int recv_idle_pct = 65;
  int random_sent = 0;
  int cycle_count = 0;

  spgemm_row_structure_counter i_dut (.*);

  spgemm_row_structure_counter_check i_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk)
    out_stall <= $urandom_range(0, 99) < recv_idle_pct;

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_word(input logic kind, input logic [COL_W-1:0] col);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_column <= col;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
  endtask

  // drain results and let the touched list clear walk finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);
    repeat (MAX_COLS + 8) @(posedge clk);
  endtask

  task automatic write_limit(input logic [VAL_W-1:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= LIMIT_ADDR;
    cfg_pwdata <= {1'($urandom_range(0, 1)), value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic send_random_row();
    int               len;
    int               style;
    int               span;
    logic [COL_W-1:0] base;
    if (random_sent < RANDOM_ITEMS / 3) begin
      send_idle_pct = 26;
      recv_idle_pct = 65;
    end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
      send_idle_pct = 65;
      recv_idle_pct = 26;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    style = $urandom_range(0, 99);
    if (style < 12) begin
      // loose words, row ends anywhere
      len = $urandom_range(1, 12);
      repeat (len)
        send_word($urandom_range(0, 3) == 0 ? KIND_ROW_END : KIND_COLUMN,
                  COL_W'($urandom));
      random_sent += len;
    end else begin
      len = (style < 14) ? $urandom_range(60, 300) : $urandom_range(0, 24);
      span = $urandom_range(0, 1) ? 16 : MAX_COLS;
      base = COL_W'($urandom);
      repeat (len)
        send_word(KIND_COLUMN, base + COL_W'($urandom_range(0, span - 1)));
      send_word(KIND_ROW_END, COL_W'($urandom));
      random_sent += len + 1;
    end
  endtask

  initial begin
    logic [VAL_W-1:0] limits [5];
    limits = '{VAL31_MAX, 31'd700, 31'd0, 31'd1, VAL31_MAX};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_word(KIND_COLUMN, '0);
    send_word(KIND_COLUMN, '1);
    send_word(KIND_COLUMN, '0);
    send_word(KIND_COLUMN, '1);
    send_word(KIND_COLUMN, 12'haaa);
    send_word(KIND_COLUMN, 12'h555);
    send_word(KIND_ROW_END, '1);
    // empty rows back to back
    send_word(KIND_ROW_END, '0);
    send_word(KIND_ROW_END, 12'h555);
    send_word(KIND_COLUMN, 12'd7);
    send_word(KIND_COLUMN, 12'd7);
    send_word(KIND_COLUMN, 12'd7);
    send_word(KIND_ROW_END, 12'haaa);
    // marks must be clear again
    send_word(KIND_COLUMN, '0);
    send_word(KIND_COLUMN, '1);
    send_word(KIND_COLUMN, 12'd7);
    send_word(KIND_ROW_END, '0);
    settle();

    foreach (limits[s]) begin
      write_limit(limits[s]);
      while (random_sent < (s + 1) * RANDOM_ITEMS / 5)
        send_random_row();
      settle();
    end

    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
